>>> src/tlex_pkg.sv
// ----------------------------------------------------------------------------
// tlex_pkg
// Shared types, token kind codes and character class helpers for the lexer.
// ----------------------------------------------------------------------------
package tlex_pkg;

  localparam logic [4:0] KIND_EOF    = 5'd0;
  localparam logic [4:0] KIND_IF     = 5'd1;
  localparam logic [4:0] KIND_ELSE   = 5'd2;
  localparam logic [4:0] KIND_END    = 5'd3;
  localparam logic [4:0] KIND_RETURN = 5'd4;
  localparam logic [4:0] KIND_IDENT  = 5'd5;
  localparam logic [4:0] KIND_NUMBER = 5'd6;
  localparam logic [4:0] KIND_LPAREN = 5'd7;
  localparam logic [4:0] KIND_RPAREN = 5'd8;
  localparam logic [4:0] KIND_LBRACK = 5'd9;
  localparam logic [4:0] KIND_RBRACK = 5'd10;
  localparam logic [4:0] KIND_COMMA  = 5'd11;
  localparam logic [4:0] KIND_GT     = 5'd12;
  localparam logic [4:0] KIND_LT     = 5'd13;
  localparam logic [4:0] KIND_EQ     = 5'd14;
  localparam logic [4:0] KIND_PLUS   = 5'd15;
  localparam logic [4:0] KIND_STAR   = 5'd16;
  localparam logic [4:0] KIND_SLASH  = 5'd17;
  localparam logic [4:0] KIND_ARROW  = 5'd18;
  localparam logic [4:0] KIND_MINUS  = 5'd19;
  localparam logic [4:0] KIND_ERROR  = 5'd20;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_GT      = 8'h3E;

  // Keywords packed big-endian, as the prefix register holds them.
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_ELSE   = 48'h0000_656C_7365;
  localparam logic [47:0] KW_END    = 48'h0000_0065_6E64;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726E;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_MINUS  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] number;
    logic [15:0] line;
    logic [31:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_ERROR;
    unique case (c)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h5B:   k = KIND_LBRACK;
      8'h5D:   k = KIND_RBRACK;
      8'h2C:   k = KIND_COMMA;
      8'h3E:   k = KIND_GT;
      8'h3C:   k = KIND_LT;
      8'h3D:   k = KIND_EQ;
      8'h2B:   k = KIND_PLUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

>>> src/token_lexer_core.sv
// ----------------------------------------------------------------------------
// token_lexer_core
// Byte-serial lexer: turns a stream of source bytes into tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel char_valid/char_stall/char_code carries one source byte per
//   word; a zero byte ends the source and yields an EOF token, after which
//   offset, line and token id counters restart.
//   Output channel token_valid/token_stall carries one token per word. A byte
//   yields zero, one or two tokens; last_of_run marks the last one of a byte.
//   Tokens of a byte go from the input register into the output queue, which
//   offers them. Throughput: one byte per cycle while the queue has room.
//   The byte stage fires when the 4-word output queue has room for two
//   tokens, so a run of two-token bytes under a stalled or slow receiver is
//   limited to the receiver's rate.
//   When the receiver stalls, queued tokens hold steady and char_stall rises
//   once the queue is nearly full and the input register is occupied.
//   Reset (rst, synchronous) empties the queue and input register, returns
//   the scanner to idle, line to 1, offset and token id to 0.
// ----------------------------------------------------------------------------
module token_lexer_core #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [4:0]  token_kind,
  output logic [31:0] token_seq,
  output logic [15:0] line_number,
  output logic [31:0] start_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);
  import tlex_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // Input register
  logic       in_full;
  logic [7:0] in_char;
  logic       consume;
  logic       accept;

  // Scanner state
  mode_t                  scan_mode, scan_mode_next;
  logic [47:0]            keyword_prefix, keyword_prefix_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [LENGTH_BITS-1:0] pending_length, pending_length_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [15:0]            line_count, line_count_next;
  logic [31:0]            next_token_id, next_token_id_next;

  // Output queue
  token_t           fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fifo_count;
  logic             pop;

  // Per-byte results
  logic             close_hit, new_hit, stop, is_eof;
  logic [4:0]       close_kind, new_kind;
  logic [15:0]      close_len, new_len;
  logic [31:0]      close_start, new_start;
  logic [4:0]       ident_kind;
  logic [1:0]       push_cnt;
  token_t           slot0, slot1;
  logic [47:0]      grown_prefix;
  logic [LENGTH_BITS-1:0] grown_length;

  assign consume    = in_full && (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
  assign char_stall = in_full && !consume;
  assign accept     = char_valid && !char_stall;
  assign pop        = token_valid && !token_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_char <= char_code;
    end
  end

  // Only the first six bytes of an identifier take part in keyword matching.
  always_comb begin
    if (pending_length < LENGTH_BITS'(6)) begin
      grown_prefix = {keyword_prefix[39:0], in_char};
    end else begin
      grown_prefix = keyword_prefix;
    end
    grown_length = (pending_length == LEN_MAX) ? pending_length
                                                : pending_length + LENGTH_BITS'(1);
  end

  always_comb begin
    priority if (pending_length == LENGTH_BITS'(2) && keyword_prefix == KW_IF) begin
      ident_kind = KIND_IF;
    end else if (pending_length == LENGTH_BITS'(4) && keyword_prefix == KW_ELSE) begin
      ident_kind = KIND_ELSE;
    end else if (pending_length == LENGTH_BITS'(3) && keyword_prefix == KW_END) begin
      ident_kind = KIND_END;
    end else if (pending_length == LENGTH_BITS'(6) && keyword_prefix == KW_RETURN) begin
      ident_kind = KIND_RETURN;
    end else begin
      ident_kind = KIND_IDENT;
    end
  end

  always_comb begin
    scan_mode_next      = scan_mode;
    keyword_prefix_next = keyword_prefix;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    byte_offset_next    = byte_offset + OFFSET_BITS'(1);
    line_count_next     = line_count;
    close_hit   = 1'b0;
    close_kind  = KIND_IDENT;
    close_start = 32'(pending_start);
    close_len   = 16'(pending_length);
    stop        = 1'b0;
    new_hit     = 1'b0;
    new_kind    = KIND_ERROR;
    new_start   = 32'(byte_offset);
    new_len     = 16'd1;
    is_eof      = 1'b0;

    // Close or extend the open token.
    unique case (scan_mode)
      MODE_IDENT: begin
        if (is_letter(in_char) || is_digit(in_char)) begin
          stop                = 1'b1;
          keyword_prefix_next = grown_prefix;
          pending_length_next = grown_length;
        end else begin
          close_hit      = 1'b1;
          close_kind     = ident_kind;
          scan_mode_next = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(in_char)) begin
          stop                = 1'b1;
          keyword_prefix_next = grown_prefix;
          pending_length_next = grown_length;
        end else begin
          close_hit      = 1'b1;
          close_kind     = KIND_NUMBER;
          scan_mode_next = MODE_IDLE;
        end
      end
      MODE_MINUS: begin
        close_hit      = 1'b1;
        scan_mode_next = MODE_IDLE;
        if (in_char == CHAR_GT) begin
          stop       = 1'b1;
          close_kind = KIND_ARROW;
          close_len  = 16'd2;
        end else begin
          close_kind = KIND_MINUS;
          close_len  = 16'd1;
        end
      end
      MODE_IDLE: begin
      end
      default: begin
      end
    endcase

    // Handle the byte itself as the start of something new.
    if (!stop) begin
      priority if (in_char == CHAR_NUL) begin
        new_hit  = 1'b1;
        new_kind = KIND_EOF;
        new_len  = 16'd0;
        is_eof   = 1'b1;
        byte_offset_next = '0;
        line_count_next  = 16'd1;
      end else if (in_char == CHAR_SPACE || in_char == CHAR_TAB ||
                   in_char == CHAR_NEWLINE) begin
        if (in_char == CHAR_NEWLINE && line_count != 16'hFFFF) begin
          line_count_next = line_count + 16'd1;
        end
      end else if (is_letter(in_char) || is_digit(in_char)) begin
        scan_mode_next      = is_letter(in_char) ? MODE_IDENT : MODE_NUMBER;
        pending_start_next  = byte_offset;
        pending_length_next = LENGTH_BITS'(1);
        keyword_prefix_next = {40'd0, in_char};
      end else if (in_char == CHAR_DASH) begin
        scan_mode_next      = MODE_MINUS;
        pending_start_next  = byte_offset;
        pending_length_next = LENGTH_BITS'(1);
      end else begin
        new_hit  = 1'b1;
        new_kind = punct_kind(in_char);
      end
    end
  end

  // Token assembly: the closed token, if any, goes first.
  always_comb begin
    push_cnt = 2'(close_hit) + 2'(new_hit);

    slot1.kind   = new_kind;
    slot1.number = next_token_id + 32'd1;
    slot1.line   = line_count;
    slot1.start  = new_start;
    slot1.length = new_len;
    slot1.last   = 1'b1;

    if (close_hit) begin
      slot0.kind   = close_kind;
      slot0.start  = close_start;
      slot0.length = close_len;
    end else begin
      slot0.kind   = new_kind;
      slot0.start  = new_start;
      slot0.length = new_len;
    end
    slot0.number = next_token_id;
    slot0.line   = line_count;
    slot0.last   = (push_cnt == 2'd1);

    next_token_id_next = is_eof ? 32'd0 : next_token_id + 32'(push_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_IDLE;
      keyword_prefix <= '0;
      pending_start  <= '0;
      pending_length <= '0;
      byte_offset    <= '0;
      line_count     <= 16'd1;
      next_token_id  <= '0;
    end else if (consume) begin
      scan_mode      <= scan_mode_next;
      keyword_prefix <= keyword_prefix_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
      byte_offset    <= byte_offset_next;
      line_count     <= line_count_next;
      next_token_id  <= next_token_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && push_cnt != 2'd0) begin
      fifo[wr_ptr] <= slot0;
    end
    if (consume && push_cnt == 2'd2) begin
      fifo[wr_ptr + PTR_W'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (consume) begin
        wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_count <= fifo_count + (consume ? CNT_W'(push_cnt) : CNT_W'(0))
                    - CNT_W'(pop);
    end
  end

  assign token_valid  = (fifo_count != '0);
  assign token_kind   = fifo[rd_ptr].kind;
  assign token_seq    = fifo[rd_ptr].number;
  assign line_number  = fifo[rd_ptr].line;
  assign start_offset = fifo[rd_ptr].start;
  assign token_length = fifo[rd_ptr].length;
  assign last_of_run  = fifo[rd_ptr].last;

  // The queue never overflows given the room check before each byte.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CNT_W'(FIFO_DEPTH))
    else $error("token queue overflow");

  // Two tokens from one byte require a token that was open before it.
  a_two_needs_open: assert property (@(posedge clk) disable iff (rst)
    (consume && push_cnt == 2'd2) |-> (scan_mode != MODE_IDLE))
    else $error("two tokens without an open token");

  // An open token always has a nonzero length.
  a_open_len: assert property (@(posedge clk) disable iff (rst)
    (scan_mode != MODE_IDLE) |-> (pending_length != '0))
    else $error("open token with zero length");

  // After end of source the counters restart.
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (consume && is_eof) |=> (byte_offset == '0 && line_count == 16'd1 &&
                             next_token_id == 32'd0))
    else $error("counters not restarted after EOF");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != 16'd0)
    else $error("line count reached zero");

endmodule
